@@ rtl/ikc_pkg.sv @@
// Package for the input key capture block: item and result structs, opcodes,
// capture states, code ranges and the gamepad mask table. No dependencies.
package ikc_pkg;

    localparam int unsigned CodeW = 9;

    localparam logic [2:0] OP_BUTTON = 3'd0;
    localparam logic [2:0] OP_BEGIN  = 3'd1;
    localparam logic [2:0] OP_CANCEL = 3'd2;
    localparam logic [2:0] OP_POLL   = 3'd3;
    localparam logic [2:0] OP_CHECK  = 3'd4;

    localparam logic [1:0] DEV_KEYBOARD = 2'd0;
    localparam logic [1:0] DEV_MOUSE    = 2'd1;
    localparam logic [1:0] DEV_GAMEPAD  = 2'd2;

    localparam logic [CodeW-1:0] CODE_NONE   = 9'd0;
    localparam logic [CodeW-1:0] MOUSE_BASE  = 9'd256;
    localparam logic [CodeW-1:0] WHEEL_FIRST = 9'd264;
    localparam logic [CodeW-1:0] PAD_BASE    = 9'd266;
    localparam logic [CodeW-1:0] CODE_MAX    = 9'd281;

    localparam logic [15:0] MOUSE_COUNT = 16'd10;
    localparam int unsigned PadCount = 16;

    localparam logic [15:0] PAD_MASKS [PadCount] = '{
        16'h0001, 16'h0002, 16'h0004, 16'h0008,
        16'h0010, 16'h0020, 16'h0040, 16'h0080,
        16'h0100, 16'h0200, 16'h1000, 16'h2000,
        16'h4000, 16'h8000, 16'h0009, 16'h000A
    };

    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_WAITING  = 2'd1,
        ST_CAPTURED = 2'd2
    } t_cap_state;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [1:0]  device;
        logic [15:0] button_id;
        logic        is_down;
        logic        is_up;
    } t_item;

    typedef struct packed {
        logic [1:0]       state_seen;
        logic [CodeW-1:0] code_out;
        logic             consumed;
    } t_result;

    typedef struct packed {
        t_cap_state       state;
        logic [CodeW-1:0] captured_code;
        logic [CodeW-1:0] held_code;
    } t_status;

endpackage

@@ rtl/input_key_capture.sv @@
// Top level of the input key capture block: input register, code mapping,
// capture control and result register. Depends on ikc_pkg, ikc_map, ikc_ctrl.
//
// Usage: items enter on i_valid / o_stall carrying an opcode (button event,
// begin capture, cancel, poll, batch consume check) and button fields. Each
// item gives exactly one result on o_valid / i_stall with the capture state
// seen before the item, the polled code and the consume flag.
// The item sits in the input register; once the result register can take it,
// the code is mapped, the state updated and the result register loaded.
// Throughput is one item per cycle unless the receiver stalls; the state update
// is a single pass of shallow logic, so items follow each other with no gap.
// When the receiver stalls, the result register holds its item and the input
// register holds the next one; o_stall rises only once both are full, so up
// to two items sit in the block during a stall.
// Reset (synchronous, active low) empties both registers and returns the
// capture state to idle with the captured and held codes cleared.
module input_key_capture (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_opcode,
    input  logic [1:0]  i_device,
    input  logic [15:0] i_button_id,
    input  logic        i_is_down,
    input  logic        i_is_up,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_state_seen,
    output logic [8:0]  o_code_out,
    output logic        o_consumed
);
    import ikc_pkg::*;

    logic             r_in_valid;
    t_item            r_in;
    logic             r_out_valid;
    t_result          r_out;
    logic             out_ready;
    logic             fire;
    logic [CodeW-1:0] code;
    t_result          result;
    t_status          status;

    assign out_ready = !r_out_valid || !i_stall;
    assign fire      = r_in_valid && out_ready;
    assign o_stall   = r_in_valid && !out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in.opcode    <= i_opcode;
            r_in.device    <= i_device;
            r_in.button_id <= i_button_id;
            r_in.is_down   <= i_is_down;
            r_in.is_up     <= i_is_up;
        end
    end

    ikc_map u_map (
        .i_device    (r_in.device),
        .i_button_id (r_in.button_id),
        .o_code      (code)
    );

    ikc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .i_code   (code),
        .o_result (result),
        .o_status (status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_state_seen = r_out.state_seen;
    assign o_code_out   = r_out.code_out;
    assign o_consumed   = r_out.consumed;

    // A nonzero polled code can only come from the captured state.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_code_out != CODE_NONE)) |-> (o_state_seen == ST_CAPTURED))
        else $error("polled code returned outside the captured state");

    // Captured state always carries a real code.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (status.state == ST_CAPTURED) |-> (status.captured_code != CODE_NONE))
        else $error("captured state with no captured code");

    // Wheel codes are never held, and held codes stay in range.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (status.held_code <= CODE_MAX) && (status.held_code != WHEEL_FIRST)
        && (status.held_code != WHEEL_FIRST + 9'd1))
        else $error("held code out of range or a wheel code");

    // The state registers move only when an item passes to the result register.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |=> $stable(status))
        else $error("capture state changed with no item processed");

endmodule

@@ rtl/ikc_map.sv @@
// Maps a device and raw button id to the unified button code (0 = no code).
// Depends on ikc_pkg for the code ranges and the gamepad mask table.
module ikc_map (
    input  logic [1:0]                i_device,
    input  logic [15:0]               i_button_id,
    output logic [ikc_pkg::CodeW-1:0] o_code
);
    import ikc_pkg::*;

    logic [3:0] pad_idx;
    logic       pad_hit;

    // The masks are distinct, so at most one entry matches.
    always_comb begin
        pad_idx = 4'd0;
        pad_hit = 1'b0;
        for (int i = 0; i < PadCount; i++) begin
            if (i_button_id == PAD_MASKS[i]) begin
                pad_idx = 4'(i);
                pad_hit = 1'b1;
            end
        end
    end

    always_comb begin
        case (i_device)
            DEV_KEYBOARD: begin
                o_code = (i_button_id < 16'(MOUSE_BASE)) ? i_button_id[CodeW-1:0]
                                                         : CODE_NONE;
            end
            DEV_MOUSE: begin
                o_code = (i_button_id < MOUSE_COUNT)
                       ? MOUSE_BASE + {5'd0, i_button_id[3:0]} : CODE_NONE;
            end
            DEV_GAMEPAD: begin
                o_code = pad_hit ? PAD_BASE + {5'd0, pad_idx} : CODE_NONE;
            end
            default: begin
                o_code = CODE_NONE;
            end
        endcase
    end

endmodule

@@ rtl/ikc_ctrl.sv @@
// Capture state machine with the captured and held code registers; forms the
// result for one item. Depends on ikc_pkg.
module ikc_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_fire,
    input  ikc_pkg::t_item            i_item,
    input  logic [ikc_pkg::CodeW-1:0] i_code,
    output ikc_pkg::t_result          o_result,
    output ikc_pkg::t_status          o_status
);
    import ikc_pkg::*;

    t_cap_state       r_state, n_state;
    logic [CodeW-1:0] r_captured, n_captured;
    logic [CodeW-1:0] r_held, n_held;
    logic             press_cap;

    assign press_cap = (i_item.opcode == OP_BUTTON) && (i_code != CODE_NONE)
                     && i_item.is_down && (r_state == ST_WAITING);

    // Next state and code registers.
    always_comb begin
        n_state    = r_state;
        n_captured = r_captured;
        n_held     = r_held;
        case (i_item.opcode)
            OP_BUTTON: begin
                if (i_code != CODE_NONE) begin
                    // The release is applied before the press.
                    if (i_item.is_up && (r_held == i_code)) begin
                        n_held = CODE_NONE;
                    end
                    if (press_cap) begin
                        n_captured = i_code;
                        n_state    = ST_CAPTURED;
                        if ((i_code < WHEEL_FIRST) || (i_code >= PAD_BASE)) begin
                            n_held = i_code;
                        end
                    end
                end
            end
            OP_BEGIN: begin
                n_state = ST_WAITING;
            end
            OP_CANCEL: begin
                if (r_state == ST_WAITING) begin
                    n_state = ST_IDLE;
                end
                n_held = CODE_NONE;
            end
            OP_POLL: begin
                if (r_state == ST_CAPTURED) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
            end
        endcase
    end

    // Result for the current item.
    always_comb begin
        o_result.state_seen = r_state;
        o_result.code_out   = CODE_NONE;
        o_result.consumed   = 1'b0;
        case (i_item.opcode)
            OP_POLL: begin
                if (r_state == ST_CAPTURED) begin
                    o_result.code_out = r_captured;
                end
            end
            OP_CHECK: begin
                o_result.consumed = (r_state == ST_WAITING) || (r_held != CODE_NONE);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_captured <= CODE_NONE;
            r_held     <= CODE_NONE;
        end else if (i_fire) begin
            r_state    <= n_state;
            r_captured <= n_captured;
            r_held     <= n_held;
        end
    end

    assign o_status.state         = r_state;
    assign o_status.captured_code = r_captured;
    assign o_status.held_code     = r_held;

endmodule

@@ tb/input_key_capture_tb.sv @@
// Self-checking testbench for input_key_capture: a directed table, partly with
// fixed results, then random items and bindings scored against a predictor.
// Depends on ikc_pkg and the input_key_capture RTL.
module input_key_capture_tb;
    import ikc_pkg::*;

    localparam logic [1:0] DEV_OTHER = 2'd3;
    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int unsigned RandItems = 1600;
    localparam int unsigned HoldCycles = 64;

    typedef struct packed {
        logic [2:0]       op;
        logic [1:0]       dev;
        logic [15:0]      id;
        logic             dn;
        logic             up;
        logic             typed;
        logic [1:0]       seen;
        logic [CodeW-1:0] code;
        logic             cons;
    } t_dir_row;

    // Rows with typed set carry their result; the rest are scored by the predictor.
    localparam t_dir_row DIR_ROWS [26] = '{
        '{OP_POLL,   DEV_KEYBOARD, 16'h0000, 1'b0, 1'b0, 1'b1, ST_IDLE,     CODE_NONE, 1'b0},
        '{OP_CHECK,  DEV_KEYBOARD, 16'h0000, 1'b0, 1'b0, 1'b1, ST_IDLE,     CODE_NONE, 1'b0},
        '{OP_BUTTON, DEV_KEYBOARD, 16'h0005, 1'b1, 1'b0, 1'b1, ST_IDLE,     CODE_NONE, 1'b0},
        '{OP_BEGIN,  DEV_OTHER,    16'hFFFF, 1'b1, 1'b1, 1'b1, ST_IDLE,     CODE_NONE, 1'b0},
        '{OP_CHECK,  DEV_KEYBOARD, 16'h0000, 1'b0, 1'b0, 1'b1, ST_WAITING,  CODE_NONE, 1'b1},
        '{OP_BUTTON, DEV_KEYBOARD, 16'h0000, 1'b1, 1'b0, 1'b1, ST_WAITING,  CODE_NONE, 1'b0},
        '{OP_BUTTON, DEV_MOUSE,    16'h000A, 1'b1, 1'b0, 1'b1, ST_WAITING,  CODE_NONE, 1'b0},
        '{OP_BUTTON, DEV_GAMEPAD,  16'h0003, 1'b1, 1'b0, 1'b1, ST_WAITING,  CODE_NONE, 1'b0},
        '{OP_BUTTON, DEV_OTHER,    16'hFFFF, 1'b1, 1'b1, 1'b1, ST_WAITING,  CODE_NONE, 1'b0},
        '{OP_POLL,   DEV_KEYBOARD, 16'h0000, 1'b0, 1'b0, 1'b1, ST_WAITING,  CODE_NONE, 1'b0},
        '{OP_BUTTON, DEV_KEYBOARD, 16'h00FF, 1'b1, 1'b0, 1'b1, ST_WAITING,  CODE_NONE, 1'b0},
        '{OP_CHECK,  DEV_KEYBOARD, 16'h0000, 1'b0, 1'b0, 1'b1, ST_CAPTURED, CODE_NONE, 1'b1},
        '{OP_POLL,   DEV_KEYBOARD, 16'h0000, 1'b0, 1'b0, 1'b1, ST_CAPTURED, 9'd255,    1'b0},
        '{OP_CHECK,  DEV_KEYBOARD, 16'h0000, 1'b0, 1'b0, 1'b1, ST_IDLE,     CODE_NONE, 1'b1},
        '{OP_BUTTON, DEV_KEYBOARD, 16'h00FF, 1'b0, 1'b1, 1'b1, ST_IDLE,     CODE_NONE, 1'b0},
        '{OP_CHECK,  DEV_KEYBOARD, 16'h0000, 1'b0, 1'b0, 1'b1, ST_IDLE,     CODE_NONE, 1'b0},
        '{OP_BEGIN,  DEV_KEYBOARD, 16'h0000, 1'b0, 1'b0, 1'b1, ST_IDLE,     CODE_NONE, 1'b0},
        '{OP_BUTTON, DEV_MOUSE,    16'h0008, 1'b1, 1'b0, 1'b1, ST_WAITING,  CODE_NONE, 1'b0},
        '{OP_BEGIN,  DEV_KEYBOARD, 16'h0000, 1'b0, 1'b0, 1'b1, ST_CAPTURED, CODE_NONE, 1'b0},
        '{OP_BUTTON, DEV_GAMEPAD,  16'h000A, 1'b1, 1'b1, 1'b0, ST_IDLE,     CODE_NONE, 1'b0},
        '{OP_CANCEL, DEV_KEYBOARD, 16'h0000, 1'b0, 1'b0, 1'b0, ST_IDLE,     CODE_NONE, 1'b0},
        '{OP_CHECK,  DEV_KEYBOARD, 16'h0000, 1'b0, 1'b0, 1'b0, ST_IDLE,     CODE_NONE, 1'b0},
        '{OP_POLL,   DEV_KEYBOARD, 16'h0000, 1'b0, 1'b0, 1'b0, ST_IDLE,     CODE_NONE, 1'b0},
        '{OP_UNUSED, DEV_MOUSE,    16'h1234, 1'b1, 1'b0, 1'b0, ST_IDLE,     CODE_NONE, 1'b0},
        '{OP_BEGIN,  DEV_KEYBOARD, 16'h0000, 1'b0, 1'b0, 1'b0, ST_IDLE,     CODE_NONE, 1'b0},
        '{OP_CANCEL, DEV_KEYBOARD, 16'h0000, 1'b0, 1'b0, 1'b0, ST_IDLE,     CODE_NONE, 1'b0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_opcode = OP_BUTTON;
    logic [1:0]  i_device = DEV_KEYBOARD;
    logic [15:0] i_button_id = 16'h0000;
    logic        i_is_down = 1'b0;
    logic        i_is_up = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_state_seen;
    logic [8:0]  o_code_out;
    logic        o_consumed;

    input_key_capture i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_opcode     (i_opcode),
        .i_device     (i_device),
        .i_button_id  (i_button_id),
        .i_is_down    (i_is_down),
        .i_is_up      (i_is_up),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_state_seen (o_state_seen),
        .o_code_out   (o_code_out),
        .o_consumed   (o_consumed)
    );

    always #4 i_clk = ~i_clk;

    // Predictor state of the capture logic.
    t_cap_state       model_state = ST_IDLE;
    logic [CodeW-1:0] model_captured = CODE_NONE;
    logic [CodeW-1:0] model_held = CODE_NONE;

    t_result     pending_results [$];
    int unsigned error_count = 0;
    int unsigned live_items = 0;
    int unsigned send_idle_pct = 27;
    int unsigned recv_idle_pct = 68;
    int unsigned hold_request = 0;
    int unsigned hold_left = 0;

    function automatic logic [CodeW-1:0] unify_code(input logic [1:0] dev,
                                                    input logic [15:0] id);
        logic [CodeW-1:0] code;
        code = CODE_NONE;
        case (dev)
            DEV_KEYBOARD: if (id < 16'(MOUSE_BASE)) code = id[CodeW-1:0];
            DEV_MOUSE:    if (id < MOUSE_COUNT) code = MOUSE_BASE + id[CodeW-1:0];
            DEV_GAMEPAD: begin
                for (int i = 0; i < PadCount; i++)
                    if (PAD_MASKS[i] == id) code = PAD_BASE + CodeW'(i);
            end
            default: code = CODE_NONE;
        endcase
        return code;
    endfunction

    function automatic t_result step_capture(input t_item it);
        t_result r;
        logic [CodeW-1:0] code;
        r.state_seen = model_state;
        r.code_out = CODE_NONE;
        r.consumed = 1'b0;
        case (it.opcode)
            OP_BUTTON: begin
                code = unify_code(it.device, it.button_id);
                if (code != CODE_NONE) begin
                    // The release half is applied before the press half.
                    if (it.is_up && model_held == code) model_held = CODE_NONE;
                    if (it.is_down && model_state == ST_WAITING) begin
                        model_captured = code;
                        model_state = ST_CAPTURED;
                        // Wheel codes are captured but never held.
                        if (code < WHEEL_FIRST || code >= PAD_BASE) model_held = code;
                    end
                end
            end
            OP_BEGIN: model_state = ST_WAITING;
            OP_CANCEL: begin
                if (model_state == ST_WAITING) model_state = ST_IDLE;
                model_held = CODE_NONE;
            end
            OP_POLL: begin
                if (model_state == ST_CAPTURED) begin
                    r.code_out = model_captured;
                    model_state = ST_IDLE;
                end
            end
            OP_CHECK: r.consumed = (model_state == ST_WAITING) || (model_held != CODE_NONE);
            default: r.consumed = 1'b0;
        endcase
        return r;
    endfunction

    // Mostly mappable buttons, with a share of raw ids that map to nothing.
    function automatic t_item rand_button(input logic down, input logic up);
        t_item it;
        int unsigned pick;
        it.opcode = OP_BUTTON;
        it.is_down = down;
        it.is_up = up;
        pick = $urandom_range(9);
        if (pick < 4) begin
            it.device = DEV_KEYBOARD;
            it.button_id = ($urandom_range(9) != 0) ? 16'($urandom_range(255, 1))
                                                   : 16'($urandom);
        end else if (pick < 6) begin
            it.device = DEV_MOUSE;
            it.button_id = ($urandom_range(9) != 0) ? 16'($urandom_range(9))
                                                   : 16'($urandom);
        end else if (pick < 9) begin
            it.device = DEV_GAMEPAD;
            it.button_id = ($urandom_range(6) != 0) ? PAD_MASKS[$urandom_range(PadCount - 1)]
                                                   : 16'($urandom);
        end else begin
            it.device = DEV_OTHER;
            it.button_id = 16'($urandom);
        end
        return it;
    endfunction

    function automatic t_item rand_any();
        t_item it;
        int unsigned pick;
        it = rand_button(1'($urandom_range(1)), 1'($urandom_range(1)));
        pick = $urandom_range(19);
        if (pick < 9) it.opcode = OP_BUTTON;
        else if (pick < 12) it.opcode = OP_BEGIN;
        else if (pick < 14) it.opcode = OP_CANCEL;
        else if (pick < 16) it.opcode = OP_POLL;
        else if (pick < 18) it.opcode = OP_CHECK;
        else it.opcode = OP_CHECK + 3'($urandom_range(3, 1));
        return it;
    endfunction

    // Offers one item, waits for it to be taken and queues its result.
    task automatic offer(input t_item it, input logic typed = 1'b0,
                         input t_result fixed = '0);
        t_result predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_opcode    <= it.opcode;
        i_device    <= it.device;
        i_button_id <= it.button_id;
        i_is_down   <= it.is_down;
        i_is_up     <= it.is_up;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predicted = step_capture(it);
        pending_results.push_back(typed ? fixed : predicted);
        if (it.opcode != OP_BUTTON || unify_code(it.device, it.button_id) != CODE_NONE)
            live_items++;
    endtask

    task automatic report_field(input string name, input int unsigned want,
                                input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left = HoldCycles;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected, actual %0d/%0d/%0d",
                         $time, o_state_seen, o_code_out, o_consumed);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                report_field("state_seen", want.state_seen, o_state_seen);
                report_field("code_out", want.code_out, o_code_out);
                report_field("consumed", want.consumed, o_consumed);
            end
        end
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        t_item    it;
        t_item    press;
        t_result  fixed;
        t_dir_row row;
        int unsigned phase;
        phase = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < $size(DIR_ROWS); r++) begin
            row = DIR_ROWS[r];
            it.opcode = row.op;
            it.device = row.dev;
            it.button_id = row.id;
            it.is_down = row.dn;
            it.is_up = row.up;
            fixed.state_seen = row.seen;
            fixed.code_out = row.code;
            fixed.consumed = row.cons;
            offer(it, row.typed, fixed);
        end

        live_items = 0;
        while (live_items < RandItems) begin
            if (phase == 0 && live_items >= RandItems / 3) begin
                phase = 1;
                send_idle_pct = 68;
                recv_idle_pct = 27;
            end else if (phase == 1 && live_items >= 2 * RandItems / 3) begin
                phase = 2;
                send_idle_pct = 0;
                recv_idle_pct = 0;
                // Hold the output long enough for the block to back up its input.
                hold_request = 1;
            end
            if ($urandom_range(99) < 70) begin
                // A binding: begin, some noise, a press, maybe a check and release, poll.
                it = rand_any();
                it.opcode = OP_BEGIN;
                offer(it);
                repeat ($urandom_range(2)) offer(rand_any());
                press = rand_button(1'b1, ($urandom_range(9) == 0));
                offer(press);
                if ($urandom_range(1) != 0) begin
                    it = rand_any();
                    it.opcode = OP_CHECK;
                    offer(it);
                end
                if ($urandom_range(1) != 0) begin
                    press.is_down = 1'b0;
                    press.is_up = 1'b1;
                    offer(press);
                end
                it = rand_any();
                it.opcode = OP_POLL;
                offer(it);
            end else begin
                offer(rand_any());
            end
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ input_key_capture.f @@
rtl/ikc_pkg.sv
rtl/ikc_map.sv
rtl/ikc_ctrl.sv
rtl/input_key_capture.sv
tb/input_key_capture_tb.sv
